// ===== hw/rtl/utf8s_pkg.sv =====
// Shared types and byte-class constants for the UTF-8 stream sanitizer.
`timescale 1ns / 1ps
package utf8s_pkg;

	localparam logic [7:0] ASCII_MAX   = 8'h7F;
	localparam logic [7:0] PRINT_MIN   = 8'h20;
	localparam logic [7:0] CHAR_TAB    = 8'h09;
	localparam logic [7:0] CHAR_LF     = 8'h0A;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CONT_MASK   = 8'hC0;
	localparam logic [7:0] CONT_CODE   = 8'h80;
	localparam logic [7:0] LEAD2_MASK  = 8'hE0;
	localparam logic [7:0] LEAD2_CODE  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK  = 8'hF0;
	localparam logic [7:0] LEAD3_CODE  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK  = 8'hF8;
	localparam logic [7:0] LEAD4_CODE  = 8'hF0;

	localparam logic [1:0] SEQ_IDLE = 2'd0;
	localparam logic [1:0] SEQ_TWO  = 2'd1;
	localparam logic [1:0] SEQ_THREE = 2'd2;
	localparam logic [1:0] SEQ_FOUR = 2'd3;

	// One finished group of output bytes: bytes[0..last_idx] go out in order.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
	} utf8s_burst_t;

	typedef struct packed {
		logic full;
		logic empty;
	} utf8s_fifo_stat_t;

endpackage

// ===== hw/rtl/utf8s_in_if.sv =====
// Input byte channel: valid/ready request carrying one raw byte.
`timescale 1ns / 1ps
interface utf8s_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       string_end;

	modport source (output valid, output in_byte, output string_end, input ready);
	modport sink (input valid, input in_byte, input string_end, output ready);
endinterface

// ===== hw/rtl/utf8s_out_if.sv =====
// Output byte channel: valid/ready request carrying one sanitized byte.
`timescale 1ns / 1ps
interface utf8s_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;

	modport source (output valid, output out_byte, output run_last, input ready);
	modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== hw/rtl/utf8_stream_sanitizer.sv =====
// Top level of the UTF-8 stream sanitizer.
// Usage:
//   in_ch takes one raw byte per request, with string_end set on the last byte
//   of a string. out_ch gives the sanitized bytes, one per request; run_last
//   marks the final byte produced for one input byte (a plain ASCII byte, or
//   the byte that completes a multi-byte sequence, which releases the lead
//   and its continuations as a group of two to four bytes).
//   A produced byte is written into the burst queue and then loaded into
//   the output register before it is valid on out_ch.
//   Throughput: one input byte per cycle on in_ch while the burst queue is
//   not full, and one output byte per cycle on out_ch while out_ch is ready;
//   the back end walks each group byte by byte into the output register.
//   The front end keeps accepting while earlier groups drain; in_ch.ready
//   falls only when the FIFO_DEPTH-entry burst queue is full.
//   Reset (arst_n low) empties the queue, clears any held partial sequence
//   and drops out_ch.valid. When out_ch stalls, the output byte holds, the
//   queue fills, and then in_ch is backpressured; nothing is lost.
`timescale 1ns / 1ps
module utf8_stream_sanitizer
	import utf8s_pkg::*;
#(
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	utf8s_in_if.sink    in_ch,
	utf8s_out_if.source out_ch
);

	utf8s_burst_t     push_burst;
	utf8s_burst_t     head_burst;
	utf8s_fifo_stat_t fifo_stat;
	logic             push;
	logic             pop;

	utf8s_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.fifo_stat (fifo_stat),
		.push      (push),
		.burst     (push_burst)
	);

	utf8s_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_burst),
		.pop     (pop),
		.rd_data (head_burst),
		.stat    (fifo_stat)
	);

	utf8s_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head_burst),
		.fifo_stat (fifo_stat),
		.pop       (pop),
		.out_ch    (out_ch)
	);

endmodule

// ===== hw/rtl/utf8s_front.sv =====
// Front end: accepts bytes, tracks held sequences, pushes finished bursts.
`timescale 1ns / 1ps
module utf8s_front
	import utf8s_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	utf8s_in_if.sink         in_ch,
	input  utf8s_fifo_stat_t fifo_stat,
	output logic             push,
	output utf8s_burst_t     burst
);

	logic [2:0][7:0] held_q;
	logic [1:0]      cnt_q;
	logic [1:0]      len_q;

	logic [1:0] cnt_d;
	logic [1:0] len_d;
	logic       emit;
	logic       store;
	logic       store_lead;
	logic       accept;
	logic       is_cont;
	logic [7:0] b;

	assign b        = in_ch.in_byte;
	assign in_ch.ready = !fifo_stat.full;
	assign accept   = in_ch.valid && in_ch.ready;
	assign is_cont  = (b & CONT_MASK) == CONT_CODE;

	always_comb begin
		cnt_d      = cnt_q;
		len_d      = len_q;
		emit       = 1'b0;
		store      = 1'b0;
		store_lead = 1'b0;
		burst.last_idx = 2'd0;
		for (int i = 0; i < 4; i++) begin
			burst.bytes[i] = b;
		end
		if (len_q != SEQ_IDLE && is_cont) begin
			if (cnt_q >= len_q) begin
				emit           = 1'b1;
				burst.last_idx = cnt_q;
				for (int i = 0; i < 3; i++) begin
					if (2'(i) < cnt_q) begin
						burst.bytes[i] = held_q[i];
					end
				end
				cnt_d = 2'd0;
				len_d = SEQ_IDLE;
			end else begin
				store = 1'b1;
				cnt_d = cnt_q + 2'd1;
			end
		end else begin
			cnt_d = 2'd0;
			len_d = SEQ_IDLE;
			priority if (b <= ASCII_MAX) begin
				emit = (b >= PRINT_MIN) || (b == CHAR_LF) || (b == CHAR_CR) ||
					(b == CHAR_TAB);
			end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
				store_lead = 1'b1;
				cnt_d      = 2'd1;
				len_d      = SEQ_TWO;
			end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
				store_lead = 1'b1;
				cnt_d      = 2'd1;
				len_d      = SEQ_THREE;
			end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
				store_lead = 1'b1;
				cnt_d      = 2'd1;
				len_d      = SEQ_FOUR;
			end else begin
				emit = 1'b0;
			end
		end
		if (in_ch.string_end) begin
			cnt_d = 2'd0;
			len_d = SEQ_IDLE;
		end
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			len_q <= SEQ_IDLE;
		end else if (accept) begin
			cnt_q <= cnt_d;
			len_q <= len_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && store) begin
			held_q[cnt_q] <= b;
		end else if (accept && store_lead) begin
			held_q[0] <= b;
		end
	end

	a_cnt_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= len_q)
		else $error("held count exceeds sequence length");
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q == SEQ_IDLE) == (cnt_q == 2'd0))
		else $error("held count and sequence length disagree on idle");

endmodule

// ===== hw/rtl/utf8s_fifo.sv =====
// Short burst queue between the front end and the output sequencer.
`timescale 1ns / 1ps
module utf8s_fifo
	import utf8s_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  utf8s_burst_t     wr_data,
	input  logic             pop,
	output utf8s_burst_t     rd_data,
	output utf8s_fifo_stat_t stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	utf8s_burst_t   mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign stat.full  = count_q == CW'(DEPTH);
	assign stat.empty = count_q == '0;
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full))
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && stat.empty))
		else $error("pop from empty queue");

endmodule

// ===== hw/rtl/utf8s_back.sv =====
// Output sequencer: walks bursts into the output register one byte per unstalled cycle.
`timescale 1ns / 1ps
module utf8s_back
	import utf8s_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  utf8s_burst_t     head,
	input  utf8s_fifo_stat_t fifo_stat,
	output logic             pop,
	utf8s_out_if.source      out_ch
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       load;
	logic       at_last;

	assign load    = !fifo_stat.empty && (!out_valid_q || out_ch.ready);
	assign at_last = idx_q == head.last_idx;
	assign pop     = load && at_last;

	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_byte = out_byte_q;
	assign out_ch.run_last = run_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head.bytes[idx_q];
			run_last_q <= at_last;
		end
	end

	a_mid_burst_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd0) |-> !fifo_stat.empty)
		else $error("burst index advanced with no burst queued");

endmodule
